@@ src/dqc_pkg.sv @@
// Shared types and constants for the DNS query check and name extract block.
// No dependencies; the parser, output queue, top level and checker import this package.
package dqc_pkg;

    // Default capacity of the name buffer, in characters.
    localparam int DQC_NAME_BUFFER = 256;

    // Output queue depth; an input byte can produce up to two result items.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Header layout.
    localparam logic [3:0] QR_POS       = 4'd2;
    localparam logic [3:0] QDCOUNT_HI   = 4'd4;
    localparam logic [3:0] QDCOUNT_LO   = 4'd5;
    localparam logic [3:0] HDR_LAST_POS = 4'd11;
    localparam logic [3:0] HDR_DONE_POS = 4'd12;

    localparam logic [7:0] MAX_LABEL_LEN = 8'd63;
    localparam logic [7:0] DOT_CHAR      = 8'h2E;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_LABEL,
        PH_PENDING,
        PH_SKIP
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_RESPONSE,
        ST_NO_QUESTION,
        ST_LABEL_LONG,
        ST_TRUNCATED,
        ST_NAME_LONG
    } t_status;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] name_char;
        logic [2:0] status;
        logic [7:0] name_length;
        logic       is_last;
    } t_item;

    // What one accepted byte produces: an optional character, then an optional verdict.
    typedef struct packed {
        logic  char_valid;
        logic  verdict_valid;
        t_item char_item;
        t_item verdict_item;
    } t_result;

endpackage

@@ src/dqc_ifs.sv @@
// Valid/ready channel interfaces for packet bytes in and result items out.
// Depends on nothing; used by the top level.
interface dqc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface dqc_out_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] name_char;
    logic [2:0] status;
    logic [7:0] name_length;
    logic       is_last;

    modport source (output valid, output item_kind, output name_char, output status,
                    output name_length, output is_last, input ready);
    modport sink   (input valid, input item_kind, input name_char, input status,
                    input name_length, input is_last, output ready);
endinterface

@@ src/dqc_parser.sv @@
// Header check and first-name label walk, one packet byte per accepted item.
// Depends on dqc_pkg.
module dqc_parser import dqc_pkg::*; #(
    parameter int NAME_BUFFER = DQC_NAME_BUFFER
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_res
);

    localparam int CW_W  = $clog2(NAME_BUFFER + 1);
    localparam int SUM_W = ((CW_W > 7) ? CW_W : 7) + 1;
    localparam int LEN_W = (CW_W > 8) ? CW_W : 8;

    logic [3:0]      r_pos,   n_pos;
    logic            r_qr,    n_qr;
    logic            r_qd,    n_qd;
    t_phase          r_phase, n_phase;
    logic [5:0]      r_left,  n_left;
    logic [CW_W-1:0] r_cw,    n_cw;
    logic            r_first, n_first;
    t_status         r_err,   n_err;

    logic [SUM_W-1:0] need;
    logic             fits;
    logic [LEN_W-1:0] cw_ext;
    t_result          res;

    // Characters needed for this label: its bytes, one spare, and one more for the dot after the first label.
    assign need = SUM_W'(r_cw) + SUM_W'(i_byte[5:0]) + (r_first ? SUM_W'(1) : SUM_W'(2));
    assign fits = (need <= SUM_W'(NAME_BUFFER));

    always_comb begin
        n_pos   = r_pos;
        n_qr    = r_qr;
        n_qd    = r_qd;
        n_phase = r_phase;
        n_left  = r_left;
        n_cw    = r_cw;
        n_first = r_first;
        n_err   = r_err;
        res     = '0;
        cw_ext  = '0;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos == QR_POS) begin
                    n_qr = i_byte[7];
                end
                if ((r_pos == QDCOUNT_HI || r_pos == QDCOUNT_LO) && i_byte != 8'd0) begin
                    n_qd = 1'b1;
                end
                if (r_pos < HDR_LAST_POS) begin
                    n_pos = r_pos + 4'd1;
                    n_err = ST_SHORT;
                end else begin
                    n_pos = HDR_DONE_POS;
                    if (r_qr) begin
                        n_err   = ST_RESPONSE;
                        n_phase = PH_SKIP;
                    end else if (!r_qd) begin
                        n_err   = ST_NO_QUESTION;
                        n_phase = PH_SKIP;
                    end else begin
                        n_err   = ST_OK;
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                if (i_byte == 8'd0) begin
                    n_phase = PH_SKIP;
                end else if (i_byte > MAX_LABEL_LEN) begin
                    n_err   = ST_LABEL_LONG;
                    n_phase = PH_SKIP;
                end else if (i_last) begin
                    n_err   = ST_TRUNCATED;
                    n_phase = PH_SKIP;
                end else begin
                    n_left = i_byte[5:0];
                    if (fits) begin
                        if (!r_first) begin
                            res.char_valid          = 1'b1;
                            res.char_item.item_kind = KIND_CHAR;
                            res.char_item.name_char = DOT_CHAR;
                            n_cw = r_cw + CW_W'(1);
                        end
                        n_phase = PH_LABEL;
                    end else begin
                        // Count the label's bytes without emitting them.
                        n_phase = PH_PENDING;
                    end
                end
            end
            PH_LABEL: begin
                res.char_valid          = 1'b1;
                res.char_item.item_kind = KIND_CHAR;
                res.char_item.name_char = i_byte;
                n_cw   = r_cw + CW_W'(1);
                n_left = r_left - 6'd1;
                if (n_left == 6'd0) begin
                    n_first = 1'b0;
                    n_phase = PH_LENGTH;
                end else if (i_last) begin
                    n_err = ST_TRUNCATED;
                end
            end
            PH_PENDING: begin
                n_left = r_left - 6'd1;
                if (n_left == 6'd0) begin
                    n_err   = ST_NAME_LONG;
                    n_phase = PH_SKIP;
                end else if (i_last) begin
                    n_err = ST_TRUNCATED;
                end
            end
            default: begin
            end
        endcase

        if (i_last) begin
            cw_ext = LEN_W'(n_cw);
            res.verdict_valid            = 1'b1;
            res.verdict_item.item_kind   = KIND_VERDICT;
            res.verdict_item.status      = n_err;
            res.verdict_item.name_length = (n_err == ST_OK) ? cw_ext[7:0] : 8'd0;
            res.verdict_item.is_last     = 1'b1;
            // Return to reset state for the next packet.
            n_pos   = '0;
            n_qr    = 1'b0;
            n_qd    = 1'b0;
            n_phase = PH_HEADER;
            n_left  = '0;
            n_cw    = '0;
            n_first = 1'b1;
            n_err   = ST_OK;
        end

        res.char_valid    = res.char_valid && i_fire;
        res.verdict_valid = res.verdict_valid && i_fire;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_qr    <= 1'b0;
            r_qd    <= 1'b0;
            r_phase <= PH_HEADER;
            r_left  <= '0;
            r_cw    <= '0;
            r_first <= 1'b1;
            r_err   <= ST_OK;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_qr    <= n_qr;
            r_qd    <= n_qd;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_cw    <= n_cw;
            r_first <= n_first;
            r_err   <= n_err;
        end
    end

endmodule

@@ src/dqc_outq.sv @@
// Small result queue: takes up to two items per cycle, hands out one when the reader is ready.
// Depends on dqc_pkg.
module dqc_outq import dqc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_res,
    output logic    o_space,
    output logic    o_valid,
    output t_item   o_item,
    input  logic    i_ready
);

    t_item            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp, n_wp;
    logic [OQ_AW-1:0] r_rp, n_rp;
    logic [OQ_CW-1:0] r_cnt, n_cnt;
    logic [1:0]       push;
    logic             pop;
    logic [OQ_AW-1:0] vd_addr;

    assign push    = {1'b0, i_res.char_valid} + {1'b0, i_res.verdict_valid};
    assign pop     = o_valid && i_ready;
    assign vd_addr = i_res.char_valid ? (r_wp + OQ_AW'(1)) : r_wp;

    always_comb begin
        n_wp  = r_wp + OQ_AW'(push);
        n_rp  = r_rp + OQ_AW'(pop);
        n_cnt = r_cnt + OQ_CW'(push) - OQ_CW'(pop);
    end

    // Room for the worst case of two items from the next byte.
    assign o_space = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_res.char_valid) begin
            r_mem[r_wp] <= i_res.char_item;
        end
        if (i_res.verdict_valid) begin
            r_mem[vd_addr] <= i_res.verdict_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/dns_query_check_and_name_extract.sv @@
// Takes one packet byte per cycle and gives back the first query name's characters, then
// one verdict item on the last byte. Each accepted byte is handled in the cycle it is
// accepted; its results enter a four-entry output queue that gives one item per cycle
// while the output is ready. A byte can produce two items (a last name character and the
// verdict), so input ready is held high while the queue has room for two; with the output
// side always ready the block takes a byte every cycle. Depends on dqc_pkg and dqc_ifs.
module dns_query_check_and_name_extract import dqc_pkg::*; #(
    parameter int NAME_BUFFER = DQC_NAME_BUFFER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dqc_in_if.sink            i_in,
    dqc_out_if.source         o_out
);

    logic    fire;
    logic    space;
    t_result res;
    t_item   head;

    assign fire       = i_in.valid && space;
    assign i_in.ready = space;

    dqc_parser #(
        .NAME_BUFFER (NAME_BUFFER)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in.byte_value),
        .i_last  (i_in.last_byte),
        .o_res   (res)
    );

    dqc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_out.valid),
        .o_item  (head),
        .i_ready (o_out.ready)
    );

    assign o_out.item_kind   = head.item_kind;
    assign o_out.name_char   = head.name_char;
    assign o_out.status      = head.status;
    assign o_out.name_length = head.name_length;
    assign o_out.is_last     = head.is_last;

endmodule

@@ src/dqc_checker.sv @@
// Port-level checks on the top level, attached by the bind below.
// Depends on dqc_pkg.
module dqc_checker import dqc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [7:0] i_out_char,
    input logic [2:0] i_out_status,
    input logic [7:0] i_out_len,
    input logic       i_out_is_last
);

    // Hold a stalled item.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_kind) && $stable(i_out_char)
             && $stable(i_out_status) && $stable(i_out_len) && $stable(i_out_is_last)))
        else $error("stalled output item changed");

    // An empty output side means the queue is empty, so input must be open.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");

    // A last byte accepted while the output is empty always yields an output item.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last && !i_out_valid) |=> i_out_valid)
        else $error("no result after last byte");

    // A failed verdict reports no name length and marks the last item.
    a_err_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == KIND_VERDICT && i_out_status != ST_OK)
            |-> (i_out_len == 8'd0 && i_out_is_last))
        else $error("bad verdict fields");

endmodule

bind dns_query_check_and_name_extract dqc_checker u_dqc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_last     (i_in.last_byte),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.item_kind),
    .i_out_char    (o_out.name_char),
    .i_out_status  (o_out.status),
    .i_out_len     (o_out.name_length),
    .i_out_is_last (o_out.is_last)
);
